/* rtl/nlp_pkg.sv */
// Shared types, character constants and digit helpers for the numeric literal parser.
`default_nettype none
package nlp_pkg;

    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_H = 8'h68;
    localparam logic [7:0] CHAR_LOWER_B = 8'h62;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] UPPER_MASK   = 8'hDF;
    localparam logic [7:0] LOWER_BIT    = 8'h20;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_RELOCATE_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELOC_BASE      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELOC_OUT_BASE  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LABEL_CHECK     = 8'd3;

    // Candidate results of the accumulators for the character being processed.
    typedef struct packed {
        logic [31:0] hex0;      // offset 0, before this character
        logic        hex0_err;
        logic [31:0] bin0;
        logic        bin0_err;
        logic [31:0] hex1;      // offsets 1 and 2, after this character
        logic        hex1_err;
        logic [31:0] bin1;
        logic        bin1_err;
        logic [31:0] hex2;
        logic        hex2_err;
        logic [31:0] bin2;
        logic        bin2_err;
        logic [31:0] dec;
        logic        dec_err;
        logic [7:0]  first;
        logic [7:0]  second;
        logic        single;    // literal is one character long
    } nlp_acc_t;

    function automatic logic is_dec_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] d;
        u = c & UPPER_MASK;
        d = u - CHAR_UPPER_A + 8'd10;
        if (is_dec_digit(c))
            return {1'b1, c[3:0]};
        else if ((u >= CHAR_UPPER_A) && (u <= CHAR_UPPER_F))
            return {1'b1, d[3:0]};
        else
            return 5'b0;
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
            return c | LOWER_BIT;
        else
            return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/nlp_accum.sv */
// Running hex, binary and decimal accumulators and character bookkeeping.
`default_nettype none
module nlp_accum (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       char_code,
    input  wire logic             is_last,
    output nlp_pkg::nlp_acc_t     acc
);

    logic [7:0]  first_char_reg, second_char_reg;
    logic [1:0]  char_position_reg, char_position_next;
    logic [31:0] hex_accum_reg [3];
    logic [31:0] hex_accum_next [3];
    logic [31:0] bin_accum_reg [3];
    logic [31:0] bin_accum_next [3];
    logic [3:0]  hex_last_reg [3];
    logic [3:0]  hex_last_next [3];
    logic        bin_last_reg [3];
    logic        bin_last_next [3];
    logic        hex_err_reg [3];
    logic        hex_err_next [3];
    logic        bin_err_reg [3];
    logic        bin_err_next [3];
    logic [31:0] dec_accum_reg, dec_accum_next;
    logic [3:0]  dec_last_reg, dec_last_next;
    logic        dec_err_reg, dec_err_next;

    logic [2:0]  feed_en;
    logic [4:0]  hd;
    logic        bin_ok, dec_ok;
    logic [3:0]  hx;
    logic        bx;

    always_comb
    begin
        feed_en = {char_position_reg[1], char_position_reg != 2'd0, 1'b1};
        hd      = nlp_pkg::hex_digit(char_code);
        bin_ok  = (char_code == nlp_pkg::CHAR_ZERO) || (char_code == nlp_pkg::CHAR_ONE);
        dec_ok  = nlp_pkg::is_dec_digit(char_code);

        for (int k = 0; k < 3; k++)
        begin
            hx = hd[4] ? hd[3:0] : hex_last_reg[k];
            bx = bin_ok ? char_code[0] : bin_last_reg[k];
            if (feed_en[k])
            begin
                hex_accum_next[k] = {hex_accum_reg[k][27:0], hx};
                hex_last_next[k]  = hx;
                hex_err_next[k]   = hex_err_reg[k] | ~hd[4];
                bin_accum_next[k] = {bin_accum_reg[k][30:0], bx};
                bin_last_next[k]  = bx;
                bin_err_next[k]   = bin_err_reg[k] | ~bin_ok;
            end
            else
            begin
                hex_accum_next[k] = hex_accum_reg[k];
                hex_last_next[k]  = hex_last_reg[k];
                hex_err_next[k]   = hex_err_reg[k];
                bin_accum_next[k] = bin_accum_reg[k];
                bin_last_next[k]  = bin_last_reg[k];
                bin_err_next[k]   = bin_err_reg[k];
            end
        end

        dec_last_next  = dec_ok ? char_code[3:0] : dec_last_reg;
        dec_err_next   = dec_err_reg | ~dec_ok;
        // times ten as two shifted adds
        dec_accum_next = {dec_accum_reg[28:0], 3'b0} + {dec_accum_reg[30:0], 1'b0}
                       + {28'b0, dec_last_next};

        char_position_next = (char_position_reg == 2'd3) ? char_position_reg
                                                          : char_position_reg + 2'd1;

        acc.hex0     = hex_accum_reg[0];
        acc.hex0_err = hex_err_reg[0];
        acc.bin0     = bin_accum_reg[0];
        acc.bin0_err = bin_err_reg[0];
        acc.hex1     = hex_accum_next[1];
        acc.hex1_err = hex_err_next[1];
        acc.bin1     = bin_accum_next[1];
        acc.bin1_err = bin_err_next[1];
        acc.hex2     = hex_accum_next[2];
        acc.hex2_err = hex_err_next[2];
        acc.bin2     = bin_accum_next[2];
        acc.bin2_err = bin_err_next[2];
        acc.dec      = dec_accum_next;
        acc.dec_err  = dec_err_next;
        acc.first    = (char_position_reg == 2'd0) ? char_code : first_char_reg;
        acc.second   = (char_position_reg == 2'd1) ? char_code : second_char_reg;
        acc.single   = (char_position_reg == 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_char_reg    <= '0;
            second_char_reg   <= '0;
            char_position_reg <= '0;
            dec_accum_reg     <= '0;
            dec_last_reg      <= '0;
            dec_err_reg       <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                hex_accum_reg[k] <= '0;
                bin_accum_reg[k] <= '0;
                hex_last_reg[k]  <= '0;
                bin_last_reg[k]  <= 1'b0;
                hex_err_reg[k]   <= 1'b0;
                bin_err_reg[k]   <= 1'b0;
            end
        end
        else if (fire)
        begin
            if (is_last)
            begin
                first_char_reg    <= '0;
                second_char_reg   <= '0;
                char_position_reg <= '0;
                dec_accum_reg     <= '0;
                dec_last_reg      <= '0;
                dec_err_reg       <= 1'b0;
                for (int k = 0; k < 3; k++)
                begin
                    hex_accum_reg[k] <= '0;
                    bin_accum_reg[k] <= '0;
                    hex_last_reg[k]  <= '0;
                    bin_last_reg[k]  <= 1'b0;
                    hex_err_reg[k]   <= 1'b0;
                    bin_err_reg[k]   <= 1'b0;
                end
            end
            else
            begin
                first_char_reg    <= acc.first;
                second_char_reg   <= acc.second;
                char_position_reg <= char_position_next;
                dec_accum_reg     <= dec_accum_next;
                dec_last_reg      <= dec_last_next;
                dec_err_reg       <= dec_err_next;
                for (int k = 0; k < 3; k++)
                begin
                    hex_accum_reg[k] <= hex_accum_next[k];
                    bin_accum_reg[k] <= bin_accum_next[k];
                    hex_last_reg[k]  <= hex_last_next[k];
                    bin_last_reg[k]  <= bin_last_next[k];
                    hex_err_reg[k]   <= hex_err_next[k];
                    bin_err_reg[k]   <= bin_err_next[k];
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/nlp_select.sv */
// Picks the literal form from its spelling and produces the final value and error.
`default_nettype none
module nlp_select (
    input  wire nlp_pkg::nlp_acc_t acc,
    input  wire logic [7:0]        char_code,
    input  wire logic [23:0]       current_address,
    input  wire logic              relocate_enable,
    input  wire logic [23:0]       reloc_base,
    input  wire logic [23:0]       reloc_out_base,
    input  wire logic              label_check,
    output logic [31:0]            value,
    output logic                   error
);

    logic [7:0]  lastl, secondl;
    logic        first_dollar, first_hash, first_pct;
    logic        last_h, last_b, rejected;
    logic [31:0] reloc_addr;

    always_comb
    begin
        lastl        = nlp_pkg::fold_lower(char_code);
        secondl      = nlp_pkg::fold_lower(acc.second);
        first_dollar = (acc.first == nlp_pkg::CHAR_DOLLAR);
        first_hash   = (acc.first == nlp_pkg::CHAR_HASH);
        first_pct    = (acc.first == nlp_pkg::CHAR_PERCENT);
        last_h       = (lastl == nlp_pkg::CHAR_LOWER_H);
        last_b       = (lastl == nlp_pkg::CHAR_LOWER_B);
        rejected     = label_check && !nlp_pkg::is_dec_digit(acc.first) && !first_dollar
                    && !first_hash && !first_pct && !last_h && !last_b;
        reloc_addr   = {8'b0, reloc_base}
                     + ({8'b0, current_address} - {8'b0, reloc_out_base});

        value = '0;
        error = 1'b0;
        if (rejected)
        begin
            error = 1'b1;
        end
        else if (first_dollar && acc.single)
        begin
            value = relocate_enable ? reloc_addr : {8'b0, current_address};
        end
        else if (first_dollar || first_hash)
        begin
            value = acc.hex1;
            error = acc.hex1_err;
        end
        else if (first_pct)
        begin
            value = acc.bin1;
            error = acc.bin1_err;
        end
        else if (acc.single)
        begin
            value = acc.dec;
            error = acc.dec_err;
        end
        else if (last_h)
        begin
            value = acc.hex0;
            error = acc.hex0_err;
        end
        else if (acc.first == nlp_pkg::CHAR_ZERO && secondl == nlp_pkg::CHAR_LOWER_X)
        begin
            value = acc.hex2;
            error = acc.hex2_err;
        end
        else if (acc.first == nlp_pkg::CHAR_ZERO && secondl == nlp_pkg::CHAR_LOWER_B)
        begin
            value = acc.bin2;
            error = acc.bin2_err;
        end
        else if (last_b)
        begin
            value = acc.bin0;
            error = acc.bin0_err;
        end
        else
        begin
            value = acc.dec;
            error = acc.dec_err;
        end
    end

endmodule
`default_nettype wire

/* rtl/numeric_literal_parser.sv */
// Top level of the numeric literal parser: input register, parse stage, result register.
//
// Usage: send the characters of one literal on the input channel, one request per
// character, with is_last high on the final one. current_address is read only on
// the final character of a lone '$'. One result (value, error) comes out per
// literal; other characters produce nothing on the output channel.
// Channels use valid/stall: a request moves when valid is high and stall is low.
// Configuration writes go on cfg_valid/cfg_ready (always ready) with cfg_index
// selecting relocate_enable, reloc_base, reloc_out_base or label_check; write
// only while no literal is in flight.
// The last character's result is registered after the input register and parse stage.
// Throughput: one character per cycle while no result is stalled, set by the single
// accumulator update in the parse stage that sits between the input and result registers.
// Reset clears configuration, all accumulators and both valid flags.
// When the receiver stalls with a result held, the parse stage holds and the input
// register fills; in_stall then rises until the result is taken.
`default_nettype none
module numeric_literal_parser (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         char_code,
    input  wire logic                               is_last,
    input  wire logic [23:0]                        current_address,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [31:0]                      value,
    output logic                                    error,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [nlp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [nlp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic        relocate_enable_reg, label_check_reg;
    logic [23:0] reloc_base_reg, reloc_out_base_reg;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic [23:0] in_addr_reg;

    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic        out_error_reg;

    logic        proc_fire, in_load;
    logic [31:0] sel_value;
    logic        sel_error;

    nlp_pkg::nlp_acc_t acc;

    assign proc_fire = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc_fire;
    assign in_load   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign error     = out_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relocate_enable_reg <= 1'b0;
            reloc_base_reg      <= '0;
            reloc_out_base_reg  <= '0;
            label_check_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                nlp_pkg::CFG_RELOCATE_ENABLE: relocate_enable_reg <= cfg_data[0];
                nlp_pkg::CFG_RELOC_BASE:      reloc_base_reg      <= cfg_data;
                nlp_pkg::CFG_RELOC_OUT_BASE:  reloc_out_base_reg  <= cfg_data;
                nlp_pkg::CFG_LABEL_CHECK:     label_check_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_load)
            in_valid_reg <= 1'b1;
        else if (proc_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_char_reg <= char_code;
            in_last_reg <= is_last;
            in_addr_reg <= current_address;
        end
    end

    nlp_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .char_code (in_char_reg),
        .is_last   (in_last_reg),
        .acc       (acc)
    );

    nlp_select u_select (
        .acc             (acc),
        .char_code       (in_char_reg),
        .current_address (in_addr_reg),
        .relocate_enable (relocate_enable_reg),
        .reloc_base      (reloc_base_reg),
        .reloc_out_base  (reloc_out_base_reg),
        .label_check     (label_check_reg),
        .value           (sel_value),
        .error           (sel_error)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_fire && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_last_reg)
        begin
            out_value_reg <= sel_value;
            out_error_reg <= sel_error;
        end
    end

endmodule
`default_nettype wire

/* rtl/nlp_checker.sv */
// Port-level assertions for the numeric literal parser, bound to the top level.
`default_nettype none
module nlp_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        is_last,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] value,
    input  wire logic        error,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(error))
        else $error("result changed while stalled");

    // input back-pressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // a fresh result traces back to an accepted last character
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && is_last, 2))
        else $error("result without a matching last character");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .error     (error),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
